// File: src/sv48w_pkg.sv
// Shared types, codes and geometry for the Sv48 page table walker.
package sv48w_pkg;

   localparam int LEVELS = 4;
   localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int VA_W   = 12 + 9 * LEVELS;
   localparam int ROOT_W = 44;
   localparam int IDX_W  = 9;

   localparam logic [LVL_W-1:0] TOP_LEVEL = LVL_W'(LEVELS - 1);

   localparam logic CMD_TRANSLATE = 1'b0;
   localparam logic CMD_ENTRY     = 1'b1;

   localparam logic [1:0] KIND_READ    = 2'd0;
   localparam logic [1:0] KIND_DONE    = 2'd1;
   localparam logic [1:0] KIND_FAULT   = 2'd2;
   localparam logic [1:0] KIND_IGNORED = 2'd3;

   localparam int PTE_V_BIT = 0;

   typedef struct packed {
      logic        cmd;
      logic [63:0] virt_addr;
      logic [63:0] table_entry;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [63:0] address;
      logic [1:0]  leaf_level;
   } rsp_type;

   typedef struct packed {
      logic             busy;
      logic [LVL_W-1:0] level;
      logic [VA_W-1:0]  vaddr;
   } walk_state_type;

endpackage

// File: src/sv48w_step.sv
// Decode of one request against the walk state: result and next state.
module sv48w_step (
   input  sv48w_pkg::req_type                 req,
   input  sv48w_pkg::walk_state_type          state,
   input  logic [sv48w_pkg::ROOT_W-1:0]       root,
   output sv48w_pkg::rsp_type                 rsp,
   output sv48w_pkg::walk_state_type          state_next
);
   import sv48w_pkg::*;

   logic [IDX_W-1:0] top_idx;
   logic [IDX_W-1:0] next_idx;
   logic [VA_W-1:0]  off_mask;
   logic [63:0]      base;
   logic [63:0]      leaf_addr;
   logic             is_leaf;

   assign top_idx = req.virt_addr[12 + 9 * (LEVELS - 1) +: IDX_W];
   assign base    = {req.table_entry[61:10], 12'b0};

   // Pick the index of the level below and the page offset mask of this level.
   always_comb begin
      next_idx = '0;
      off_mask = '0;
      for (int i = 0; i < LEVELS; i++) begin
         if (state.level == LVL_W'(i)) begin
            off_mask = {VA_W{1'b1}} >> (VA_W - 12 - 9 * i);
            if (i > 0) begin
               next_idx = state.vaddr[12 + 9 * (i > 0 ? i - 1 : 0) +: IDX_W];
            end
         end
      end
   end

   assign leaf_addr = base + 64'(state.vaddr & off_mask);
   assign is_leaf   = (|req.table_entry[3:1]) || (state.level == '0);

   always_comb begin
      rsp        = '0;
      state_next = state;
      rsp.kind   = KIND_IGNORED;
      if (req.cmd == CMD_TRANSLATE) begin
         if (!state.busy) begin
            state_next.busy  = 1'b1;
            state_next.level = TOP_LEVEL;
            state_next.vaddr = req.virt_addr[VA_W-1:0];
            rsp.kind         = KIND_READ;
            rsp.address      = 64'({root, top_idx, 3'b000});
            rsp.leaf_level   = TOP_LEVEL[1:0];
         end
      end else if (state.busy) begin
         rsp.leaf_level = state.level[1:0];
         if (!req.table_entry[PTE_V_BIT]) begin
            state_next.busy = 1'b0;
            rsp.kind        = KIND_FAULT;
         end else if (is_leaf) begin
            state_next.busy = 1'b0;
            rsp.kind        = KIND_DONE;
            rsp.address     = leaf_addr;
         end else begin
            state_next.level = state.level - LVL_W'(1);
            rsp.kind         = KIND_READ;
            rsp.address      = {req.table_entry[61:10], next_idx, 3'b000};
            rsp.leaf_level   = state_next.level[1:0];
         end
      end
   end

endmodule

// File: src/sv48_page_table_walker.sv
// Top level of the Sv48 page table walker: input stage, walk state, result stage.
//
// Requests enter on req_valid/req_stall/req_data. cmd 0 starts a walk and is
// answered with a read of the top-level table entry; cmd 1 hands back the entry
// read from memory and is answered with the next read, the translated address
// or a fault. A request that does not fit the walk state is answered as ignored.
// Every request gives exactly one result on rsp_valid/rsp_stall/rsp_data.
// A request is accepted into the input register, then decoded against the
// walk state into the result register. While req_stall is low, one request
// per cycle is accepted; the walk state updates as each request is decoded.
// csr_write_enable loads the root page number; write it only while no walk runs.
// Reset (synchronous) empties both stages, clears the walk state and the root.
// While rsp_stall holds a valid result, the result holds, a request in the
// input register waits there and req_stall is high until the result is taken.
module sv48_page_table_walker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [sv48w_pkg::ROOT_W-1:0]  csr_write_data,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  sv48w_pkg::req_type            req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output sv48w_pkg::rsp_type            rsp_data
);
   import sv48w_pkg::*;

   logic                 in_valid_ff;
   req_type              in_data_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_data_ff;
   rsp_type              rsp_data_in;
   walk_state_type       state_ff;
   walk_state_type       state_in;
   logic [ROOT_W-1:0]    root_ff;
   logic                 advance;

   sv48w_step u_step (
      .req        (in_data_ff),
      .state      (state_ff),
      .root       (root_ff),
      .rsp        (rsp_data_in),
      .state_next (state_in)
   );

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
         root_ff      <= '0;
      end else begin
         if (csr_write_enable) begin
            root_ff <= csr_write_data;
         end
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= in_valid_ff;
            if (in_valid_ff) begin
               state_ff <= state_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data;
      end
      if (advance && in_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

// File: src/sv48w_checker.sv
// Port-level checks for the Sv48 page table walker, bound to the top level.
module sv48w_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_stall,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input sv48w_pkg::rsp_type  rsp_data
);
   import sv48w_pkg::*;

   // Hold a stalled result.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // Drop everything at reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("result pending after reset");

   a_ignored_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == KIND_IGNORED |->
         rsp_data.address == '0 && rsp_data.leaf_level == '0)
      else $error("ignored result carries data");

   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == KIND_FAULT |-> rsp_data.address == '0)
      else $error("fault result carries an address");

   // Entry reads are 8-byte aligned.
   a_read_aligned: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == KIND_READ |-> rsp_data.address[2:0] == 3'b000)
      else $error("unaligned entry read");

endmodule

bind sv48_page_table_walker sv48w_checker u_sv48w_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
